// File: hw/rtl/midi_note_echo_scheduler_unit_assert.svh
// Assertion macros for the echo scheduler checker.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef MIDI_NOTE_ECHO_SCHEDULER_UNIT_ASSERT_SVH
`define MIDI_NOTE_ECHO_SCHEDULER_UNIT_ASSERT_SVH

// A condition that holds at every edge.
`define MNES_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mnes assertion failed");

// A trigger that forces a condition at the next edge.
`define MNES_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("mnes assertion failed");

`endif

// File: hw/rtl/mnes_pkg.sv
// ----------------------------------------------------------------------------
// mnes_pkg
// Shared types and codes of the MIDI note echo scheduler.
// ----------------------------------------------------------------------------
package mnes_pkg;

	localparam int unsigned ECHO_WORDS = 4;
	localparam int unsigned RESULT_CAP = 32;
	localparam int unsigned WORD_W     = 40;

	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_TICK     = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		EV_ECHO_ON  = 2'd0,
		EV_ECHO_OFF = 2'd1,
		EV_DROPPED  = 2'd2,
		EV_UNUSED   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_ECHO_COUNT = 3'd0,
		REG_ECHO_WORD0 = 3'd1,
		REG_ECHO_WORD1 = 3'd2,
		REG_ECHO_WORD2 = 3'd3,
		REG_ECHO_WORD3 = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REL_EV,
		ST_EVAL,
		ST_EMIT_ON,
		ST_EMIT_OFF,
		ST_WB,
		ST_FIN,
		ST_DROP
	} st_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] chan;
		logic [6:0] key;
		logic [6:0] vel;
	} res_t;

	typedef struct packed {
		logic       due;
		logic       inrange;
		logic [6:0] key;
		logic [6:0] vel;
	} echo_t;

	// Timing, transpose and velocity scaling of one echo word.
	function automatic echo_t echo_eval(input logic [WORD_W-1:0] w, input logic [6:0] key,
			input logic [6:0] vel, input logic [31:0] since, input logic [31:0] now);
		echo_t             r;
		logic [31:0]       el;
		logic signed [8:0] k;
		logic [18:0]       prod;
		logic [10:0]       sh;
		el        = now - since;
		r.due     = (el >= {12'd0, w[19:0]});
		k         = $signed({2'b00, key}) + $signed({w[27], w[27:20]});
		r.inrange = !k[8] && !k[7];
		r.key     = k[6:0];
		prod      = 19'(vel) * 19'(w[39:28]);
		sh        = prod[18:8];
		r.vel     = (sh > 11'd127) ? 7'd127 : sh[6:0];
		return r;
	endfunction

endpackage

// File: hw/rtl/mnes_ram.sv
// ----------------------------------------------------------------------------
// mnes_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mnes_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hw/rtl/midi_note_echo_scheduler_unit.sv
// ----------------------------------------------------------------------------
// midi_note_echo_scheduler_unit
// Live-note table with tick-driven on/off echoes, held in two RAMs.
// ----------------------------------------------------------------------------
// Channel   Dir  Group    Contents
// s_axis    in   stream   tuser opcode; tdata chan, key_number, strike_velocity
// m_axis    out  stream   tuser event_kind; tdata out_chan, out_key, out_velocity;
//                         tlast last_of_run
// cfg       in   write    cfg_index selects echo_count or echo_word_0..3
//
// Note-on stores the entry at the fill count; a note-on with velocity zero acts
// as note-off. Note-off scans the entries in order, bounded by the single read
// port of the table RAMs. A tick walks every live entry through evaluation, any
// echo sends and write-back, then a final flush; the registered RAM read sets
// this walk. No clearing pass after reset: the fill count marks valid entries.
// Output stalls hold the walk; the input is taken only between items.
// ----------------------------------------------------------------------------
module midi_note_echo_scheduler_unit #(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned MAX_ECHOES  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [3:0] chan, [10:4] key_number, [17:11] strike_velocity
	input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [3:0] out_chan, [10:4] out_key, [17:11] out_velocity
	output logic [1:0]  m_axis_tuser,  // [1:0] event_kind
	output logic        m_axis_tlast,  // last_of_run
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [mnes_pkg::WORD_W-1:0] cfg_data
);
	import mnes_pkg::*;

	localparam int unsigned AW  = $clog2(TABLE_DEPTH);
	localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IW  = $clog2(MAX_ECHOES + 1);
	localparam int unsigned IFW = 26 + 2 * IW;
	localparam int unsigned LIM = (MAX_ECHOES < ECHO_WORDS) ? MAX_ECHOES : ECHO_WORDS;

	// Configuration registers.
	logic [2:0]        echo_count_q;
	logic [WORD_W-1:0] word_q [ECHO_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_count_q <= '0;
			for (int j = 0; j < ECHO_WORDS; j++) begin
				word_q[j] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ECHO_COUNT: echo_count_q <= cfg_data[2:0];
				REG_ECHO_WORD0: word_q[0] <= cfg_data;
				REG_ECHO_WORD1: word_q[1] <= cfg_data;
				REG_ECHO_WORD2: word_q[2] <= cfg_data;
				REG_ECHO_WORD3: word_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Active echo count: clamp to both the word count and the index range.
	logic [2:0] cnt;
	assign cnt = (echo_count_q > 3'(LIM)) ? 3'(LIM) : echo_count_q;

	// Input fields.
	logic        s_acc;
	logic [1:0]  in_op;
	logic [3:0]  in_chan;
	logic [6:0]  in_key;
	logic [6:0]  in_vel;
	assign in_op   = s_axis_tuser;
	assign in_chan = s_axis_tdata[3:0];
	assign in_key  = s_axis_tdata[10:4];
	assign in_vel  = s_axis_tdata[17:11];

	// Control state.
	st_t         st_q, st_nx;
	logic [31:0] tick_q;
	logic [CW-1:0] used_q, i_q, wp_q;
	logic [5:0]  n_q;
	logic        stop_q;
	logic [3:0]  rel_chan_q;
	logic [6:0]  rel_key_q, rel_vel_q;

	// Entry held between evaluation and write-back.
	logic [IFW-1:0] ent_q;
	logic [63:0]    tim_q;
	logic           on_send_q, off_send_q, free_q;
	res_t           on_res_q, off_res_q;

	// Pending result (not yet known whether last) and output register.
	res_t pend_q;
	logic pend_v_q;
	res_t out_q;
	logic out_last_q, out_v_q;
	logic out_free, push_ok;
	assign out_free = !out_v_q || m_axis_tready;
	assign push_ok  = !pend_v_q || out_free;

	// Table RAMs.
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [IFW-1:0] info_wdata, info_rdata;
	logic [63:0]    time_wdata, time_rdata;

	mnes_ram #(.WIDTH(IFW), .DEPTH(TABLE_DEPTH)) u_info_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (info_wdata),
		.raddr (ram_raddr),
		.rdata (info_rdata)
	);

	mnes_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (time_wdata),
		.raddr (ram_raddr),
		.rdata (time_rdata)
	);

	// Unpack the entry read from the RAM: {off_idx, on_idx, rel, off_vel, on_vel, key, chan}.
	logic [3:0]    r_chan;
	logic [6:0]    r_key, r_on_vel, r_off_vel;
	logic          r_rel;
	logic [IW-1:0] r_on_idx, r_off_idx;
	assign r_chan    = info_rdata[3:0];
	assign r_key     = info_rdata[10:4];
	assign r_on_vel  = info_rdata[17:11];
	assign r_off_vel = info_rdata[24:18];
	assign r_rel     = info_rdata[25];
	assign r_on_idx  = info_rdata[26 +: IW];
	assign r_off_idx = info_rdata[26 + IW +: IW];

	// Echo evaluation of the entry just read.
	echo_t         on_e, off_e;
	logic          on_ok, off_ok, on_adv, off_adv;
	logic [IW-1:0] new_on, new_off;
	logic          ev_free, ev_stop;
	logic          i_last;

	always_comb begin
		on_e    = echo_eval(word_q[2'(r_on_idx)], r_key, r_on_vel, time_rdata[31:0], tick_q);
		off_e   = echo_eval(word_q[2'(r_off_idx)], r_key, r_off_vel, time_rdata[63:32], tick_q);
		on_ok   = 8'(r_on_idx) < 8'(cnt);
		off_ok  = r_rel && (8'(r_off_idx) < 8'(cnt));
		on_adv  = on_ok && on_e.due;
		off_adv = off_ok && off_e.due;
		new_on  = r_on_idx + IW'(on_adv);
		new_off = r_off_idx + IW'(off_adv);
		ev_stop = stop_q || (n_q > 6'(RESULT_CAP - 2));
		ev_free = !ev_stop && (8'(new_on) >= 8'(cnt)) && (8'(new_off) >= 8'(cnt));
	end

	assign i_last = (i_q + CW'(1)) >= used_q;

	// Next state.
	always_comb begin
		st_nx = st_q;
		case (st_q)
			ST_IDLE: begin
				if (s_acc) begin
					case (in_op)
						OP_NOTE_ON: begin
							if (in_vel == 7'd0) begin
								st_nx = (used_q == '0) ? ST_IDLE : ST_REL_EV;
							end else if (used_q >= CW'(TABLE_DEPTH)) begin
								st_nx = ST_DROP;
							end
						end
						OP_NOTE_OFF: st_nx = (used_q == '0) ? ST_IDLE : ST_REL_EV;
						OP_TICK:     st_nx = (used_q == '0) ? ST_IDLE : ST_EVAL;
						default:     st_nx = ST_IDLE;
					endcase
				end
			end
			ST_REL_EV: begin
				if ((!r_rel && r_chan == rel_chan_q && r_key == rel_key_q) || i_last) begin
					st_nx = ST_IDLE;
				end
			end
			ST_EVAL: begin
				if (!ev_stop && on_adv && on_e.inrange) begin
					st_nx = ST_EMIT_ON;
				end else if (!ev_stop && off_adv && off_e.inrange) begin
					st_nx = ST_EMIT_OFF;
				end else begin
					st_nx = ST_WB;
				end
			end
			ST_EMIT_ON: begin
				if (push_ok) begin
					st_nx = off_send_q ? ST_EMIT_OFF : ST_WB;
				end
			end
			ST_EMIT_OFF: begin
				if (push_ok) begin
					st_nx = ST_WB;
				end
			end
			ST_WB:   st_nx = i_last ? ST_FIN : ST_EVAL;
			ST_FIN:  if (!pend_v_q || out_free) st_nx = ST_IDLE;
			ST_DROP: if (out_free) st_nx = ST_IDLE;
			default: st_nx = ST_IDLE;
		endcase
	end

	// Outputs of the controller: RAM ports and handshake.
	logic rel_hit;
	assign rel_hit = !r_rel && r_chan == rel_chan_q && r_key == rel_key_q;

	always_comb begin
		s_axis_tready = (st_q == ST_IDLE);
		ram_we        = 1'b0;
		ram_waddr     = used_q[AW-1:0];
		ram_raddr     = '0;
		info_wdata    = ent_q;
		time_wdata    = tim_q;
		case (st_q)
			ST_IDLE: begin
				// Note-on store at the fill count; read entry 0 for scans.
				ram_we     = s_acc && in_op == OP_NOTE_ON && in_vel != 7'd0 &&
					used_q < CW'(TABLE_DEPTH);
				ram_waddr  = used_q[AW-1:0];
				info_wdata = {IW'(0), IW'(0), 1'b0, 7'd0, in_vel, in_key, in_chan};
				time_wdata = {tick_q, tick_q};
			end
			ST_REL_EV: begin
				ram_we     = rel_hit;
				ram_waddr  = i_q[AW-1:0];
				info_wdata = {r_off_idx, r_on_idx, 1'b1, rel_vel_q, r_on_vel, r_key, r_chan};
				time_wdata = {tick_q, time_rdata[31:0]};
				ram_raddr  = AW'(i_q + CW'(1));
			end
			ST_WB: begin
				// Keep survivors packed from the bottom, in order.
				ram_we    = !free_q;
				ram_waddr = wp_q[AW-1:0];
				ram_raddr = AW'(i_q + CW'(1));
			end
			default: ;
		endcase
	end

	assign s_acc = s_axis_tvalid && s_axis_tready;

	// Push a result into the pending slot; the slot's old content moves out.
	logic push;
	res_t push_res;
	always_comb begin
		push     = 1'b0;
		push_res = on_res_q;
		case (st_q)
			ST_EMIT_ON:  push = push_ok;
			ST_EMIT_OFF: begin
				push     = push_ok;
				push_res = off_res_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			tick_q     <= '0;
			used_q     <= '0;
			i_q        <= '0;
			wp_q       <= '0;
			n_q        <= '0;
			stop_q     <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			case (st_q)
				ST_IDLE: begin
					i_q    <= '0;
					wp_q   <= '0;
					n_q    <= '0;
					stop_q <= 1'b0;
					if (s_acc) begin
						if (in_op == OP_TICK) begin
							tick_q <= tick_q + 32'd1;
						end
						if (ram_we) begin
							used_q <= used_q + CW'(1);
						end
					end
				end
				ST_REL_EV: i_q <= i_q + CW'(1);
				ST_EVAL:   stop_q <= ev_stop;
				ST_WB: begin
					i_q <= i_q + CW'(1);
					if (!free_q) begin
						wp_q <= wp_q + CW'(1);
					end
					if (i_last) begin
						used_q <= free_q ? wp_q : wp_q + CW'(1);
					end
				end
				default: ;
			endcase

			if (push) begin
				n_q      <= n_q + 6'd1;
				pend_v_q <= 1'b1;
			end else if (st_q == ST_FIN && out_free) begin
				pend_v_q <= 1'b0;
			end

			if ((push && pend_v_q) || (st_q == ST_FIN && pend_v_q && out_free) ||
					(st_q == ST_DROP && out_free)) begin
				out_v_q    <= 1'b1;
				out_last_q <= (st_q != ST_EMIT_ON && st_q != ST_EMIT_OFF);
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			rel_chan_q <= in_chan;
			rel_key_q  <= in_key;
			rel_vel_q  <= (in_op == OP_NOTE_ON) ? 7'd0 : in_vel;
			pend_q     <= '{kind: EV_DROPPED, chan: in_chan, key: in_key, vel: in_vel};
		end
		if (st_q == ST_EVAL) begin
			tim_q      <= time_rdata;
			free_q     <= ev_free;
			on_send_q  <= !ev_stop && on_adv && on_e.inrange;
			off_send_q <= !ev_stop && off_adv && off_e.inrange;
			on_res_q   <= '{kind: EV_ECHO_ON, chan: r_chan, key: on_e.key, vel: on_e.vel};
			off_res_q  <= '{kind: EV_ECHO_OFF, chan: r_chan, key: off_e.key, vel: off_e.vel};
			if (ev_stop) begin
				ent_q <= info_rdata;
			end else begin
				ent_q <= {new_off, new_on, info_rdata[25:0]};
			end
		end
		if (push) begin
			pend_q <= push_res;
		end
		if ((push && pend_v_q) || (st_q == ST_FIN && pend_v_q && out_free) ||
				(st_q == ST_DROP && out_free)) begin
			// In the drop state the pending slot holds the dropped note.
			out_q <= pend_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {6'd0, out_q.vel, out_q.key, out_q.chan};
	assign m_axis_tlast  = out_last_q;

	// on_send_q is consulted only through the state sequence.
	logic unused_on_send;
	assign unused_on_send = on_send_q;
endmodule

// File: hw/rtl/mnes_checker.sv
// ----------------------------------------------------------------------------
// mnes_checker
// Port-level checks of the echo scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "midi_note_echo_scheduler_unit_assert.svh"

module mnes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic [mnes_pkg::WORD_W-1:0] cfg_data
);
	import mnes_pkg::*;

	// A stalled item holds its payload.
	`MNES_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
	// A dropped note is always the only result of its item.
	`MNES_ALWAYS(a_drop_last, !(m_axis_tvalid && m_axis_tuser == EV_DROPPED) || m_axis_tlast)
	// Result kinds never take the unused code.
	`MNES_ALWAYS(a_kind_ok, !m_axis_tvalid || m_axis_tuser != EV_UNUSED)
	// An item with the unused opcode leaves the input open for the next cycle.
	`MNES_NEXT(a_none_idle, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_NONE, s_axis_tready)

	logic unused;
	assign unused = ^{s_axis_tdata, cfg_we, cfg_index, cfg_data};
endmodule

bind midi_note_echo_scheduler_unit mnes_checker u_mnes_checker (.*);
